### rtl/bpfc_pkg.sv
// Shared types and constants for the binary pattern frequency counter.
// Used by the top, bpfc_ctrl, bpfc_checker and the testbench; depends on nothing else.

package bpfc_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_LEN     = 12;
   localparam int DEF_COUNT_WIDTH = 18;

   // Configuration register port.
   localparam int CFG_W     = 4;
   localparam int CFG_IDX_W = 1;

   localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'd0;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'd1;

   localparam logic [CFG_W-1:0] MIN_LENGTH_RESET = 4'd1;
   localparam logic [CFG_W-1:0] MAX_LENGTH_RESET = 4'd12;

   // Request function codes.
   localparam logic FUNC_PUSH  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Stream characters that extend the window.
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_ONE  = 8'h31;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD,
      ST_WR,
      ST_QRD,
      ST_QOUT
   } state_type;

endpackage

### rtl/binary_pattern_frequency_counter.sv
// Binary pattern frequency counter: a push beat is followed by one read-modify-write
// of the count table per counted length, a read state then a write state each. A
// query beat is read in ST_QRD and loaded into the result register in ST_QOUT once
// that register is free; one beat is in work at a time, ready is low meanwhile.
// After reset a clearing pass zeroes all 2^(MAX_LEN+1) entries (8192 at default) of
// the table with ready low; configuration writes are taken during it.

module binary_pattern_frequency_counter import bpfc_pkg::*; #(
   parameter int MAX_LEN     = DEF_MAX_LEN,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
   localparam int LEN_W      = $clog2(MAX_LEN + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CFG_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   input  logic [7:0]             req_symbol,
   input  logic [LEN_W-1:0]       req_query_length,
   input  logic [MAX_LEN-1:0]     req_query_pattern,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COUNT_WIDTH-1:0] rsp_pattern_count
);

   localparam int AW = MAX_LEN + 1;

   logic [CFG_W-1:0]       min_len_ff, min_len_in;
   logic [CFG_W-1:0]       max_len_ff, max_len_in;
   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [COUNT_WIDTH-1:0] mem_wr_data;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [COUNT_WIDTH-1:0] mem_rd_data;

   // Register decode of the configuration port.
   always_comb begin
      min_len_in = min_len_ff;
      max_len_in = max_len_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_MIN_LENGTH: min_len_in = csr_wdata;
            REG_MAX_LENGTH: max_len_in = csr_wdata;
            default: begin
               min_len_in = min_len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= MIN_LENGTH_RESET;
         max_len_ff <= MAX_LENGTH_RESET;
      end else begin
         min_len_ff <= min_len_in;
         max_len_ff <= max_len_in;
      end
   end

   bpfc_ctrl #(
      .MAX_LEN     (MAX_LEN),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .min_length        (min_len_ff),
      .max_length        (max_len_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_symbol        (req_symbol),
      .req_query_length  (req_query_length),
      .req_query_pattern (req_query_pattern),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pattern_count (rsp_pattern_count),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data)
   );

   bpfc_table #(
      .AW (AW),
      .DW (COUNT_WIDTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

### rtl/bpfc_table.sv
// Count table: single-write, single-read memory with registered read data.
// Depends on nothing; sized by its parameters.

module bpfc_table #(
   parameter int AW = 13,
   parameter int DW = 18
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bpfc_ctrl.sv
// Sequencer of the pattern counter: history window, clearing pass,
// one read-modify-write of the count table per counted length, query reads.
// Depends on bpfc_pkg; drives the ports of bpfc_table.

module bpfc_ctrl import bpfc_pkg::*; #(
   parameter int MAX_LEN     = DEF_MAX_LEN,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
   localparam int LEN_W      = $clog2(MAX_LEN + 1),
   localparam int AW         = MAX_LEN + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CFG_W-1:0]       min_length,
   input  logic [CFG_W-1:0]       max_length,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   input  logic [7:0]             req_symbol,
   input  logic [LEN_W-1:0]       req_query_length,
   input  logic [MAX_LEN-1:0]     req_query_pattern,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COUNT_WIDTH-1:0] rsp_pattern_count,
   output logic                   mem_wr_en,
   output logic [AW-1:0]          mem_wr_addr,
   output logic [COUNT_WIDTH-1:0] mem_wr_data,
   output logic                   mem_rd_en,
   output logic [AW-1:0]          mem_rd_addr,
   input  logic [COUNT_WIDTH-1:0] mem_rd_data
);

   // Length arithmetic must hold both the configuration values and MAX_LEN.
   localparam int LW = (LEN_W > CFG_W) ? LEN_W : CFG_W;

   state_type              state_ff, state_in;
   logic [LW-1:0]          len_ff, len_in;
   logic [LW-1:0]          end_ff, end_in;
   logic [MAX_LEN-1:0]     hist_ff, hist_in;
   logic [LEN_W-1:0]       fill_ff, fill_in;
   logic [MAX_LEN-1:0]     qpat_ff, qpat_in;
   logic                   qbad_ff, qbad_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   logic [MAX_LEN-1:0]     idx_bits;
   logic [AW-1:0]          idx;
   logic [LW-1:0]          lo_len;
   logic [LW-1:0]          hi_len;
   logic [LEN_W-1:0]       fill_next;
   logic [LW-1:0]          span_end;
   logic                   is_bin;
   logic                   push_bit;
   logic                   out_free;
   logic [COUNT_WIDTH-1:0] count_inc;

   // Table index of a pattern: a leading one above the low len bits.
   always_comb begin
      idx = (AW'(1) << len_ff) | ({1'b0, idx_bits} & ~({AW{1'b1}} << len_ff));
   end

   // Configured length range and the span that the window covers.
   always_comb begin
      lo_len    = (min_length == '0) ? LW'(1) : LW'(min_length);
      hi_len    = (LW'(max_length) > LW'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(max_length);
      fill_next = (fill_ff < LEN_W'(MAX_LEN)) ? fill_ff + LEN_W'(1) : fill_ff;
      span_end  = (hi_len < LW'(fill_next)) ? hi_len : LW'(fill_next);
      is_bin    = (req_symbol == ASCII_ZERO) || (req_symbol == ASCII_ONE);
      push_bit  = (req_symbol == ASCII_ONE);
      out_free  = !rsp_valid_ff || rsp_ready;
      count_inc = (mem_rd_data == {COUNT_WIDTH{1'b1}}) ? mem_rd_data
                                                       : mem_rd_data + COUNT_WIDTH'(1);
   end

   // Next state and outputs of the sequencer.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      end_in       = end_ff;
      hist_in      = hist_ff;
      fill_in      = fill_ff;
      qpat_in      = qpat_ff;
      qbad_in      = qbad_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      idx_bits     = hist_ff;
      req_ready    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx;
      mem_wr_data  = count_inc;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx;

      case (state_ff)
         // Zero the whole table, one entry a cycle, after reset.
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_func)
                  FUNC_QUERY: begin
                     len_in   = LW'(req_query_length);
                     qpat_in  = req_query_pattern;
                     qbad_in  = (req_query_length == '0) ||
                                (req_query_length > LEN_W'(MAX_LEN));
                     state_in = ST_QRD;
                  end
                  FUNC_PUSH: begin
                     if (is_bin) begin
                        hist_in = MAX_LEN'({hist_ff, push_bit});
                        fill_in = fill_next;
                        len_in  = lo_len;
                        end_in  = span_end;
                        if (lo_len <= span_end) begin
                           state_in = ST_RD;
                        end
                     end else begin
                        hist_in = '0;
                        fill_in = '0;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Read the counter of the current length.
         ST_RD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_WR;
         end

         // Write back the saturated increment, then step to the next length or, after the last, go idle.
         ST_WR: begin
            mem_wr_en = 1'b1;
            if (len_ff == end_ff) begin
               state_in = ST_IDLE;
            end else begin
               len_in   = len_ff + LW'(1);
               state_in = ST_RD;
            end
         end

         ST_QRD: begin
            idx_bits  = qpat_ff;
            mem_rd_en = 1'b1;
            state_in  = ST_QOUT;
         end

         // Load the result register once it is free.
         ST_QOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = qbad_ff ? '0 : mem_rd_data;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hist_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hist_ff      <= hist_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      end_ff       <= end_in;
      qpat_ff      <= qpat_in;
      qbad_ff      <= qbad_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pattern_count = rsp_count_ff;

endmodule

### rtl/bpfc_checker.sv
// Port-level checks of the binary pattern frequency counter, bound to the top.
// Depends on bpfc_pkg and binary_pattern_frequency_counter.

module bpfc_checker import bpfc_pkg::*; #(
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_func,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COUNT_WIDTH-1:0] rsp_pattern_count
);

   // A result beat that is not taken holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pattern_count))
      else $error("stalled result beat changed");

   // The clearing pass keeps the request side closed right after reset.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during clearing pass");

   // A push beat never produces a result.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_PUSH && !rsp_valid |=> !rsp_valid)
      else $error("result beat appeared for a push");

   // A query keeps the block busy until its result is formed.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_QUERY |=> !req_ready ##1 !req_ready)
      else $error("request taken while a query is in work");

endmodule

bind binary_pattern_frequency_counter bpfc_checker #(
   .COUNT_WIDTH (COUNT_WIDTH)
) u_bpfc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_func          (req_func),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_pattern_count (rsp_pattern_count)
);

### dv/testbench.sv
// Self-checking testbench for binary_pattern_frequency_counter.
// Depends on rtl/bpfc_pkg.sv and the counter itself: a directed table, then random
// pushes and queries, checked against an in-bench model of the pattern count table.
`timescale 1ns / 100ps

module testbench;
   import bpfc_pkg::*;

   localparam int MAX_LEN        = DEF_MAX_LEN;
   localparam int COUNT_WIDTH    = DEF_COUNT_WIDTH;
   localparam int LEN_W          = $clog2(MAX_LEN + 1);
   localparam int TALLY_DEPTH    = 1 << (MAX_LEN + 1);
   localparam int COUNT_MAX      = (1 << COUNT_WIDTH) - 1;
   localparam int NO_TYPED       = -1;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 50000;
   localparam int ITEMS_PER_STEP = 110;
   localparam int N_ROWS         = 24;
   localparam int N_STEPS        = 8;

   typedef struct {
      logic                  func;
      logic [7:0]            symbol;
      logic [LEN_W-1:0]      qlen;
      logic [MAX_LEN-1:0]    qpat;
      int                    typed;
   } stim_row_type;

   typedef struct {
      logic [CFG_W-1:0] lo;
      logic [CFG_W-1:0] hi;
      int               send_pct;
      int               stall_pct;
   } setting_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CFG_IDX_W-1:0]   csr_index;
   logic [CFG_W-1:0]       csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_func;
   logic [7:0]             req_symbol;
   logic [LEN_W-1:0]       req_query_length;
   logic [MAX_LEN-1:0]     req_query_pattern;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [COUNT_WIDTH-1:0] rsp_pattern_count;

   // Model state: window, configuration and the flat count table.
   logic [MAX_LEN-1:0]     win_bits;
   int                     win_fill;
   logic [CFG_W-1:0]       min_len_cfg;
   logic [CFG_W-1:0]       max_len_cfg;
   logic [COUNT_WIDTH-1:0] pattern_tally [TALLY_DEPTH];
   logic [COUNT_WIDTH-1:0] expected_counts [$];

   int typed_count;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_request;
   int hold_left;
   int idle_cycles;
   int err_count;
   int n_push;
   int n_query;
   int n_checked;
   int n_settings;

   // Directed beats; typed counts are the ones obvious from reset and the few pushes.
   stim_row_type dir_rows [N_ROWS] = '{
      '{FUNC_QUERY, 8'h00,      4'd1,  12'h000, 0},
      '{FUNC_QUERY, 8'hFF,      4'd12, 12'hFFF, 0},
      '{FUNC_QUERY, 8'h00,      4'd0,  12'h000, 0},
      '{FUNC_QUERY, 8'h00,      4'd15, 12'hFFF, 0},
      '{FUNC_QUERY, 8'h00,      4'd13, 12'h000, 0},
      '{FUNC_PUSH,  ASCII_ONE,  4'd0,  12'h000, NO_TYPED},
      '{FUNC_PUSH,  ASCII_ZERO, 4'd15, 12'hFFF, NO_TYPED},
      '{FUNC_PUSH,  ASCII_ONE,  4'd0,  12'h000, NO_TYPED},
      '{FUNC_QUERY, 8'h00,      4'd1,  12'h001, 2},
      '{FUNC_QUERY, 8'h00,      4'd3,  12'h005, 1},
      '{FUNC_QUERY, 8'h00,      4'd2,  12'hFFE, NO_TYPED},
      '{FUNC_PUSH,  8'h00,      4'd0,  12'h000, NO_TYPED},
      '{FUNC_PUSH,  8'hFF,      4'd15, 12'hFFF, NO_TYPED},
      '{FUNC_PUSH,  ASCII_ONE,  4'd0,  12'h000, NO_TYPED},
      '{FUNC_QUERY, 8'h00,      4'd2,  12'h003, NO_TYPED},
      '{FUNC_PUSH,  ASCII_ONE,  4'd0,  12'h000, NO_TYPED},
      '{FUNC_PUSH,  ASCII_ONE,  4'd0,  12'h000, NO_TYPED},
      '{FUNC_PUSH,  ASCII_ONE,  4'd0,  12'h000, NO_TYPED},
      '{FUNC_PUSH,  ASCII_ONE,  4'd0,  12'h000, NO_TYPED},
      '{FUNC_PUSH,  ASCII_ONE,  4'd0,  12'h000, NO_TYPED},
      '{FUNC_PUSH,  ASCII_ONE,  4'd0,  12'h000, NO_TYPED},
      '{FUNC_QUERY, 8'h00,      4'd7,  12'h07F, NO_TYPED},
      '{FUNC_QUERY, 8'h00,      4'd12, 12'h000, NO_TYPED},
      '{FUNC_QUERY, 8'h00,      4'd1,  12'h000, NO_TYPED}
   };

   // Register settings and idling per random stretch, extremes included.
   setting_type settings [N_STEPS] = '{
      '{4'd1,  4'd12, 0,  0},
      '{4'd0,  4'd15, 62, 0},
      '{4'd12, 4'd12, 0,  62},
      '{4'd1,  4'd1,  20, 20},
      '{4'd5,  4'd3,  0,  0},
      '{4'd0,  4'd0,  62, 0},
      '{4'd15, 4'd15, 0,  62},
      '{4'd3,  4'd9,  20, 20}
   };

   binary_pattern_frequency_counter dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_symbol        (req_symbol),
      .req_query_length  (req_query_length),
      .req_query_pattern (req_query_pattern),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pattern_count (rsp_pattern_count)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      err_count++;
   endtask

   // Shift one stream character into the window and bump the covered counters.
   task automatic shift_symbol(input logic [7:0] sym);
      int lo;
      int hi;
      int idx;
      if (sym == ASCII_ZERO || sym == ASCII_ONE) begin
         lo = (min_len_cfg == 0) ? 1 : int'(min_len_cfg);
         hi = (max_len_cfg > MAX_LEN) ? MAX_LEN : int'(max_len_cfg);
         win_bits = {win_bits[MAX_LEN-2:0], sym[0]};
         if (win_fill < MAX_LEN) win_fill++;
         for (int len = lo; len <= hi && len <= win_fill; len++) begin
            idx = ((1 << len) | (int'(win_bits) & ((1 << len) - 1))) & (TALLY_DEPTH - 1);
            if (pattern_tally[idx] < COUNT_MAX) pattern_tally[idx]++;
         end
      end else begin
         win_bits = '0;
         win_fill = 0;
      end
   endtask

   function automatic logic [COUNT_WIDTH-1:0] lookup_count(input logic [LEN_W-1:0] len,
                                                           input logic [MAX_LEN-1:0] pat);
      int idx;
      if (len == 0 || len > MAX_LEN) return '0;
      idx = ((1 << len) | (int'(pat) & ((1 << len) - 1))) & (TALLY_DEPTH - 1);
      return pattern_tally[idx];
   endfunction

   // Monitor: register writes, accepted beats and result checks, all at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_MIN_LENGTH: min_len_cfg = csr_wdata;
               REG_MAX_LENGTH: max_len_cfg = csr_wdata;
               default: ;
            endcase
         end
         // Results first, so a same-edge request cannot be matched against itself.
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("result beat %0d with nothing pending",
                                         rsp_pattern_count));
            end else begin
               if (rsp_pattern_count !== expected_counts[0])
                  report_mismatch($sformatf("pattern_count %0d, expected %0d",
                                            rsp_pattern_count, expected_counts[0]));
               void'(expected_counts.pop_front());
               n_checked++;
            end
         end
         if (req_valid && req_ready) begin
            if (req_func == FUNC_PUSH) begin
               n_push++;
               shift_symbol(req_symbol);
            end else begin
               n_query++;
               if (typed_count >= 0)
                  expected_counts.push_back(typed_count[COUNT_WIDTH-1:0]);
               else
                  expected_counts.push_back(lookup_count(req_query_length,
                                                         req_query_pattern));
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offer one request beat and hold it until the block takes it.
   task automatic send_beat(input logic func, input logic [7:0] sym,
                            input logic [LEN_W-1:0] qlen, input logic [MAX_LEN-1:0] qpat,
                            input int typed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_func          = func;
      req_symbol        = sym;
      req_query_length  = qlen;
      req_query_pattern = qpat;
      typed_count       = typed;
      req_valid         = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Mostly binary characters with rare breaks, and queries aimed at the live window.
   task automatic send_random_item();
      int r;
      logic [7:0] sym;
      logic [LEN_W-1:0] qlen;
      logic [MAX_LEN-1:0] qpat;
      sym  = 8'($urandom_range(255));
      qlen = LEN_W'($urandom_range(15));
      qpat = MAX_LEN'($urandom_range(4095));
      r    = int'($urandom_range(99));
      if (r < 55) begin
         send_beat(FUNC_PUSH, $urandom_range(1) ? ASCII_ONE : ASCII_ZERO, qlen, qpat,
                   NO_TYPED);
      end else if (r < 61) begin
         send_beat(FUNC_PUSH, sym, qlen, qpat, NO_TYPED);
      end else begin
         if ($urandom_range(99) < 88) qlen = LEN_W'($urandom_range(MAX_LEN, 1));
         if ($urandom_range(1)) qpat = win_bits;
         send_beat(FUNC_QUERY, sym, qlen, qpat, NO_TYPED);
      end
   endtask

   // Quiet the request side, drain pending results, then let a last push finish.
   task automatic settle();
      req_valid = 1'b0;
      while (expected_counts.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Main sequence.
   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = REG_MIN_LENGTH;
      csr_wdata         = '0;
      req_valid         = 1'b0;
      req_func          = FUNC_PUSH;
      req_symbol        = '0;
      req_query_length  = '0;
      req_query_pattern = '0;
      rsp_ready         = 1'b0;
      typed_count       = NO_TYPED;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      hold_request      = 1'b0;
      hold_left         = 0;
      idle_cycles       = 0;
      err_count         = 0;
      n_push            = 0;
      n_query           = 0;
      n_checked         = 0;
      n_settings        = 0;
      win_bits          = '0;
      win_fill          = 0;
      min_len_cfg       = MIN_LENGTH_RESET;
      max_len_cfg       = MAX_LENGTH_RESET;
      foreach (pattern_tally[i]) pattern_tally[i] = '0;

      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed part at reset settings.
      for (int i = 0; i < N_ROWS; i++)
         send_beat(dir_rows[i].func, dir_rows[i].symbol, dir_rows[i].qlen,
                   dir_rows[i].qpat, dir_rows[i].typed);

      // Random stretches, each under its own register setting and idling.
      for (int s = 0; s < N_STEPS; s++) begin
         settle();
         cfg_write(REG_MIN_LENGTH, settings[s].lo);
         cfg_write(REG_MAX_LENGTH, settings[s].hi);
         n_settings++;
         send_idle_pct  = settings[s].send_pct;
         recv_stall_pct = settings[s].stall_pct;
         if (s == 2) begin
            // Long receiver hold-off while queries keep coming, so the input backs up.
            hold_request = 1'b1;
            send_beat(FUNC_QUERY, 8'h00, 4'd12, win_bits, NO_TYPED);
         end
         repeat (ITEMS_PER_STEP) send_random_item();
      end

      req_valid = 1'b0;
      while (expected_counts.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d pushes and %0d queries over %0d register settings",
               n_push, n_query, n_settings);
      $display("%0d counts compared, %0d mismatches", n_checked, err_count);
      if (err_count == 0 && expected_counts.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### binary_pattern_frequency_counter.f
rtl/bpfc_pkg.sv
rtl/bpfc_table.sv
rtl/bpfc_ctrl.sv
rtl/binary_pattern_frequency_counter.sv
rtl/bpfc_checker.sv
dv/testbench.sv
